### hw/rtl/xyzluv_pkg.sv
// shared constants, types and white point tables for the xyz to luv converter
package xyzluv_pkg;

  localparam int SEL_W       = 3;
  localparam int WHITE_COUNT = 7;
  localparam int Q_W         = 23;
  localparam int UV_FRAC     = 20;
  localparam int DIFF_W      = 24;
  localparam int CHROMA_W    = 24;
  localparam int L_W         = 16;
  localparam int DATA_W      = 32;

  localparam int LUMA_THRESHOLD = 145;
  localparam int CUBE_K         = 116;
  localparam int CUBE_BIAS      = 32;
  localparam int CUBE_SHIFT     = 6;
  localparam int L_OFFSET       = 4096;
  localparam int LIN_A_W        = 21;
  localparam int LIN_K          = 9033;
  localparam int LIN_BIAS       = 320;
  localparam int LIN_RECIP      = 1677722;
  localparam int LIN_SHIFT      = 30;
  localparam int LIN_W          = 12;
  localparam int CHROMA_K       = 13;

  localparam logic REG_ILLUM_SEL = 1'b0;

  typedef enum logic [SEL_W-1:0] {
    ILLUM_E   = 3'd0,
    ILLUM_DIN = 3'd1,
    ILLUM_A   = 3'd2,
    ILLUM_A2  = 3'd3,
    ILLUM_C   = 3'd4,
    ILLUM_C2  = 3'd5,
    ILLUM_D65 = 3'd6
  } illum_e;

  localparam illum_e ILLUM_RESET = ILLUM_D65;

  // u'n of each white point, 20 fraction bits
  function automatic logic [UV_FRAC-1:0] white_upn(input logic [SEL_W-1:0] sel);
    logic [UV_FRAC-1:0] v;
    unique case (sel) inside
      ILLUM_E:           v = 20'd220753;
      ILLUM_DIN:         v = 20'd207553;
      ILLUM_A, ILLUM_A2: v = 20'd268380;
      ILLUM_C, ILLUM_C2: v = 20'd210625;
      default:           v = 20'd207418;
    endcase
    return v;
  endfunction

  // v'n of each white point, 20 fraction bits
  function automatic logic [UV_FRAC-1:0] white_vpn(input logic [SEL_W-1:0] sel);
    logic [UV_FRAC-1:0] v;
    unique case (sel) inside
      ILLUM_E:           v = 20'd496694;
      ILLUM_DIN:         v = 20'd491061;
      ILLUM_A, ILLUM_A2: v = 20'd549795;
      ILLUM_C, ILLUM_C2: v = 20'd483376;
      default:           v = 20'd491151;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/xyzluv_div.sv
// pipelined restoring divider, one quotient bit per stage
module xyzluv_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 21,
  parameter int QUO_W = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o
);

  logic             valid_q [QUO_W];
  logic [DEN_W-1:0] rem_q   [QUO_W];
  logic [QUO_W-1:0] low_q   [QUO_W];
  logic [DEN_W-1:0] den_q   [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic             valid_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign low_in   = num_i[QUO_W-1:0];
      assign den_in   = den_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign low_in   = low_q[s-1];
      assign den_in   = den_q[s-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[s] <= {low_in[QUO_W-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = low_q[QUO_W-1];

endmodule

### hw/rtl/xyzluv_cbrt.sv
// pipelined integer cube root of y scaled by 2^28, one root bit per stage
module xyzluv_cbrt #(
  parameter int IN_W   = 16,
  parameter int ROOT_W = 15
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   y_i,
  output logic [IN_W-1:0]   y_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int SQ_W = 2 * ROOT_W;
  localparam int CU_W = 3 * ROOT_W;
  localparam int SCALE = 28;
  localparam logic [CU_W-1:0] ONE = CU_W'(1);

  logic [IN_W-1:0]   y_q   [ROOT_W];
  logic [ROOT_W-1:0] res_q [ROOT_W];
  logic [SQ_W-1:0]   sq_q  [ROOT_W];
  logic [CU_W-1:0]   cu_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [IN_W-1:0]   y_in;
    logic [ROOT_W-1:0] res_in;
    logic [SQ_W-1:0]   sq_in;
    logic [CU_W-1:0]   cu_in;
    logic [CU_W-1:0]   res_x;
    logic [CU_W-1:0]   sq_x;
    logic [CU_W-1:0]   cand_sq;
    logic [CU_W-1:0]   cand_cu;
    logic [CU_W-1:0]   target;
    logic              fits;

    if (s == 0) begin : g_first
      assign y_in   = y_i;
      assign res_in = '0;
      assign sq_in  = '0;
      assign cu_in  = '0;
    end else begin : g_next
      assign y_in   = y_q[s-1];
      assign res_in = res_q[s-1];
      assign sq_in  = sq_q[s-1];
      assign cu_in  = cu_q[s-1];
    end

    assign res_x   = CU_W'(res_in);
    assign sq_x    = CU_W'(sq_in);
    assign cand_sq = sq_x + (res_x << (B + 1)) + (ONE << (2 * B));
    assign cand_cu = cu_in + (((sq_x << 1) + sq_x) << B)
                   + (((res_x << 1) + res_x) << (2 * B)) + (ONE << (3 * B));
    assign target  = CU_W'(y_in) << SCALE;
    assign fits    = cand_cu <= target;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s] <= y_in;
        if (fits) begin
          res_q[s] <= res_in | ROOT_W'(ONE << B);
          sq_q[s]  <= cand_sq[SQ_W-1:0];
          cu_q[s]  <= cand_cu;
        end else begin
          res_q[s] <= res_in;
          sq_q[s]  <= sq_in;
          cu_q[s]  <= cu_in;
        end
      end
    end
  end

  assign y_o    = y_q[ROOT_W-1];
  assign root_o = res_q[ROOT_W-1];

endmodule

### hw/rtl/xyzluv_light.sv
// lightness from cube root or linear segment, delayed to meet the divider
module xyzluv_light
  import xyzluv_pkg::*;
#(
  parameter int IN_W   = 16,
  parameter int ROOT_W = 15,
  parameter int LQ_W   = 16,
  parameter int DEPTH  = 6
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   y_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [LQ_W-1:0]   lq_o
);

  localparam int CUBE_W = ROOT_W + 7;
  localparam int PROD_W = 2 * LIN_A_W;

  logic [CUBE_W-1:0]  cube_q;
  logic [LIN_A_W-1:0] lin_a_q;
  logic               big_q;
  logic [LQ_W-1:0]    lq_q;
  logic [LQ_W-1:0]    dly_q [DEPTH];
  logic [PROD_W-1:0]  lin_p;
  logic [ROOT_W:0]    cube_l;
  logic [LQ_W-1:0]    lq_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cube_q  <= CUBE_W'(root_i) * CUBE_W'(CUBE_K) + CUBE_W'(CUBE_BIAS);
      lin_a_q <= LIN_A_W'(y_i[7:0]) * LIN_A_W'(LIN_K) + LIN_A_W'(LIN_BIAS);
      big_q   <= y_i > IN_W'(LUMA_THRESHOLD);
    end
  end

  assign lin_p  = PROD_W'(lin_a_q) * PROD_W'(LIN_RECIP);
  assign cube_l = cube_q[CUBE_W-1:CUBE_SHIFT] - (ROOT_W + 1)'(L_OFFSET);
  assign lq_d   = big_q ? LQ_W'(cube_l) : LQ_W'(lin_p[LIN_SHIFT+LIN_W-1:LIN_SHIFT]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lq_q <= lq_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[i] <= (i == 0) ? lq_q : dly_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign lq_o = dly_q[DEPTH-1];

endmodule

### hw/rtl/xyz_to_luv_pixel_top.sv
// top level of the cie xyz to cie l*u*v* pixel converter
// Converts one XYZ pixel (unsigned, 14 fraction bits) per clock into L* (Q8.8,
// saturating) and u*, v* (signed, 8 fraction bits, saturating), against the white
// point chosen by the illuminant select register at address 0 (values past the
// table clamp to the last white point). From input transfer to output register,
// the a and b stages form the sum and the dividends, a 23-stage restoring divider
// gives u' and v' one bit per stage while the cube root and lightness run beside
// it, and the m1, m2 and output registers form and round the chroma products.
// One pixel is accepted each cycle; a stall on the output holds the whole pipeline.
// Write the register only while no pixel is in flight.
module xyz_to_luv_pixel_top
  import xyzluv_pkg::*;
#(
  parameter int ILLUMINANT_COUNT = 7,
  parameter int INPUT_WIDTH      = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [INPUT_WIDTH-1:0]     x_value_i,
  input  logic [INPUT_WIDTH-1:0]     y_value_i,
  input  logic [INPUT_WIDTH-1:0]     z_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [L_W-1:0]             lightness_o,
  output logic signed [CHROMA_W-1:0] u_star_o,
  output logic signed [CHROMA_W-1:0] v_star_o
);

  localparam int IW     = INPUT_WIDTH;
  localparam int T_W    = IW + 5;
  localparam int NUM_W  = IW + 25;
  localparam int ROOT_W = (IW + 30) / 3;
  localparam int LQ_W   = ROOT_W + 1;
  localparam int M_W    = LQ_W + 4;
  localparam int P_W    = M_W + 1 + DIFF_W;
  localparam int SAT_W  = ((LQ_W > L_W) ? LQ_W : L_W) + 1;
  localparam int DLY    = Q_W - ROOT_W - 2;
  localparam int LIM    = (ILLUMINANT_COUNT > WHITE_COUNT) ? WHITE_COUNT :
                          ((ILLUMINANT_COUNT < 1) ? 1 : ILLUMINANT_COUNT);
  localparam logic [SEL_W-1:0] SEL_RESET =
    (int'(ILLUM_RESET) >= LIM) ? SEL_W'(LIM - 1) : SEL_W'(ILLUM_RESET);
  localparam logic [P_W-1:0] HALF    = P_W'(1) << (UV_FRAC - 1);
  localparam logic [P_W-1:0] POS_MAX = P_W'((1 << (CHROMA_W - 1)) - 1);
  localparam logic [P_W-1:0] NEG_MAX = P_W'(1 << (CHROMA_W - 1));

  logic [SEL_W-1:0] sel_q;
  logic [SEL_W-1:0] wr_sel;
  logic             en;

  logic             a_valid_q;
  logic [IW-1:0]    a_x_q;
  logic [IW-1:0]    a_y_q;
  logic [T_W-1:0]   a_t_q;
  logic             b_valid_q;
  logic [NUM_W-1:0] b_num_u_q;
  logic [NUM_W-1:0] b_num_v_q;
  logic [T_W-1:0]   b_den_q;
  logic [IW-1:0]    b_y_q;

  logic             c_valid;
  logic [Q_W-1:0]   c_up;
  logic [Q_W-1:0]   c_vp;
  logic [IW-1:0]    r_y;
  logic [ROOT_W-1:0] r_root;
  logic [LQ_W-1:0]  c_lq;

  logic                     m1_valid_q;
  logic [M_W-1:0]           m1_m_q;
  logic signed [DIFF_W-1:0] m1_du_q;
  logic signed [DIFF_W-1:0] m1_dv_q;
  logic [L_W-1:0]           m1_l_q;
  logic [SAT_W-1:0]         lq_ext;
  logic                     m2_valid_q;
  logic signed [P_W-1:0]    m2_pu_q;
  logic signed [P_W-1:0]    m2_pv_q;
  logic [L_W-1:0]           m2_l_q;
  logic                     out_valid_q;

  function automatic logic [CHROMA_W-1:0] chroma_sat(input logic signed [P_W-1:0] p);
    logic           neg;
    logic [P_W-1:0] mag;
    logic [P_W-1:0] r;
    neg = p[P_W-1];
    mag = neg ? P_W'(-p) : P_W'(p);
    r   = (mag + HALF) >> UV_FRAC;
    if (neg) begin
      if (r > NEG_MAX) r = NEG_MAX;
      r = P_W'(-r);
    end else begin
      if (r > POS_MAX) r = POS_MAX;
    end
    return r[CHROMA_W-1:0];
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign wr_sel = ({1'b0, pwdata[SEL_W-1:0]} >= (SEL_W + 1)'(LIM)) ?
                  SEL_W'(LIM - 1) : pwdata[SEL_W-1:0];
  assign prdata = (paddr[2] == REG_ILLUM_SEL) ? DATA_W'(sel_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ILLUM_SEL) begin
      sel_q <= wr_sel;
    end
  end

  // pipeline advance
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      m1_valid_q  <= c_valid;
      m2_valid_q  <= m1_valid_q;
      out_valid_q <= m2_valid_q;
    end
  end

  // sum and dividends
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q <= x_value_i;
      a_y_q <= y_value_i;
      a_t_q <= T_W'(x_value_i) + (T_W'(y_value_i) << 4) - T_W'(y_value_i)
             + (T_W'(z_value_i) << 1) + T_W'(z_value_i);
      b_num_u_q <= (NUM_W'(a_x_q) << (UV_FRAC + 2)) + NUM_W'(a_t_q >> 1);
      b_num_v_q <= (((NUM_W'(a_y_q) << 3) + NUM_W'(a_y_q)) << UV_FRAC)
                 + NUM_W'(a_t_q >> 1);
      b_den_q   <= a_t_q;
      b_y_q     <= a_y_q;
    end
  end

  xyzluv_div #(.NUM_W(NUM_W), .DEN_W(T_W), .QUO_W(Q_W)) u_div_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   (b_num_u_q),
    .den_i   (b_den_q),
    .valid_o (c_valid),
    .quo_o   (c_up)
  );

  xyzluv_div #(.NUM_W(NUM_W), .DEN_W(T_W), .QUO_W(Q_W)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   (b_num_v_q),
    .den_i   (b_den_q),
    .valid_o (),
    .quo_o   (c_vp)
  );

  xyzluv_cbrt #(.IN_W(IW), .ROOT_W(ROOT_W)) u_cbrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (b_y_q),
    .y_o    (r_y),
    .root_o (r_root)
  );

  xyzluv_light #(.IN_W(IW), .ROOT_W(ROOT_W), .LQ_W(LQ_W), .DEPTH(DLY)) u_light (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (r_y),
    .root_i (r_root),
    .lq_o   (c_lq)
  );

  // chroma products
  assign lq_ext = SAT_W'(c_lq);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_m_q  <= (M_W'(c_lq) << 3) + (M_W'(c_lq) << 2) + M_W'(c_lq);
      m1_du_q <= $signed(DIFF_W'(c_up)) - $signed(DIFF_W'(white_upn(sel_q)));
      m1_dv_q <= $signed(DIFF_W'(c_vp)) - $signed(DIFF_W'(white_vpn(sel_q)));
      m1_l_q  <= (lq_ext > SAT_W'({L_W{1'b1}})) ? {L_W{1'b1}} : lq_ext[L_W-1:0];
      m2_pu_q <= P_W'($signed({1'b0, m1_m_q}) * m1_du_q);
      m2_pv_q <= P_W'($signed({1'b0, m1_m_q}) * m1_dv_q);
      m2_l_q  <= m1_l_q;
      lightness_o <= m2_l_q;
      u_star_o    <= chroma_sat(m2_pu_q);
      v_star_o    <= chroma_sat(m2_pv_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### verif/testbench.sv
// self-checking testbench for the xyz to luv pixel converter
`timescale 1ns / 100ps

module testbench;
  import xyzluv_pkg::*;

  localparam int LATENCY_WAIT = 48;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REG_UNUSED   = 1;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } xyz_t;

  typedef struct packed {
    logic [L_W-1:0]      l;
    logic [CHROMA_W-1:0] u;
    logic [CHROMA_W-1:0] v;
  } luv_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [15:0]         x_value_i = '0, y_value_i = '0, z_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [L_W-1:0]      lightness_o;
  logic [CHROMA_W-1:0] u_star_o, v_star_o;

  xyz_t   xyz_pending_q[$];
  luv_t   luv_expected_q[$];
  illum_e white_sel = ILLUM_RESET;
  int     mismatches = 0;
  int     cycles = 0;
  int     gap_left = 0, burst_left = 4;
  int     stall_mode = 0;

  xyz_to_luv_pixel_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [CHROMA_W-1:0] chroma_q8(longint lq8, longint diff);
    longint          prod;
    longint unsigned mag, r;
    prod = 13 * lq8 * diff;
    mag = (prod < 0) ? longint'(-prod) : longint'(prod);
    r = (mag + (64'd1 << 19)) >> 20;
    if (prod < 0) begin
      if (r > 64'd8388608) r = 64'd8388608;
      return CHROMA_W'(-longint'(r));
    end
    if (r > 64'd8388607) r = 64'd8388607;
    return CHROMA_W'(r);
  endfunction

  function automatic luv_t predict_luv(xyz_t p, illum_e sel);
    int unsigned     wx[7] = '{16384, 15581, 17995, 17995, 16063, 16063, 15568};
    int unsigned     wz[7] = '{16384, 17842, 5825, 5825, 19350, 19350, 17827};
    longint unsigned tn, upn, vpn, t, up, vp, c, cand, ycube;
    longint          lq8;
    luv_t            r;
    tn = wx[sel] + 15 * 16384 + 3 * wz[sel];
    upn = round_div(longint'(4 * wx[sel]) << 20, tn);
    vpn = round_div(longint'(9 * 16384) << 20, tn);
    t = p.x + 15 * longint'(p.y) + 3 * longint'(p.z);
    up = 0;
    vp = 0;
    if (t != 0) begin
      up = round_div(longint'(4 * longint'(p.x)) << 20, t);
      vp = round_div(longint'(9 * longint'(p.y)) << 20, t);
    end
    if (p.y > 145) begin
      ycube = longint'(p.y) << 28;
      c = 0;
      for (int b = 20; b >= 0; b--) begin
        cand = c | (64'd1 << b);
        if (cand * cand * cand <= ycube) c = cand;
      end
      lq8 = longint'((116 * c + 32) >> 6) - 4096;
    end else begin
      lq8 = (9033 * longint'(p.y) + 320) / 640;
    end
    r.l = (lq8 < 0) ? '0 : (lq8 > 65535) ? 16'hffff : L_W'(lq8);
    r.u = chroma_q8(lq8, longint'(up) - longint'(upn));
    r.v = chroma_q8(lq8, longint'(vp) - longint'(vpn));
    return r;
  endfunction

  function automatic xyz_t random_xyz();
    xyz_t p;
    p = {16'($urandom), 16'($urandom), 16'($urandom)};
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: p.y = 16'($urandom_range(120, 170));
      4: p.y = 16'($urandom_range(0, 145));
      5: begin
        p.x = 16'($urandom_range(0, 3)) * p.x;
        p.z = 16'($urandom_range(0, 1)) * p.z;
      end
      6: p = {16'($urandom_range(65000, 65535)), 16'($urandom_range(65000, 65535)),
              16'($urandom_range(65000, 65535))};
      default: p = {16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)),
                    16'($urandom_range(0, 20000))};
    endcase
    return p;
  endfunction

  task automatic reg_write(int index, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_ILLUM_SEL) white_sel = illum_e'((value[2:0] > 6) ? 6 : value[2:0]);
  endtask

  task automatic drain();
    while (xyz_pending_q.size() != 0 || luv_expected_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  // input driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        luv_expected_q.push_back(predict_luv({x_value_i, y_value_i, z_value_i}, white_sel));
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (xyz_pending_q.size() != 0) begin
          {x_value_i, y_value_i, z_value_i} <= xyz_pending_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    luv_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= (cycles % 5 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
      if (out_valid_o && !out_stall_i) begin
        if (luv_expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transfer at cycle %0d", cycles);
        end else begin
          want = luv_expected_q.pop_front();
          if (want !== {lightness_o, u_star_o, v_star_o}) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch L exp %h got %h, u exp %h got %h, v exp %h got %h",
                       want.l, lightness_o, want.u, u_star_o, want.v, v_star_o);
          end
        end
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int sel_plan[8] = '{-1, 0, 1, 2, 3, 4, 5, 7};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    xyz_pending_q.push_back({16'd0, 16'd0, 16'd0});
    xyz_pending_q.push_back({16'hffff, 16'hffff, 16'hffff});
    xyz_pending_q.push_back({16'd0, 16'd145, 16'd0});
    xyz_pending_q.push_back({16'd0, 16'd146, 16'd0});
    xyz_pending_q.push_back({16'd1000, 16'd145, 16'd2000});
    xyz_pending_q.push_back({16'd1000, 16'd146, 16'd2000});
    xyz_pending_q.push_back({16'hffff, 16'd0, 16'd0});
    xyz_pending_q.push_back({16'd0, 16'd0, 16'hffff});
    xyz_pending_q.push_back({16'd0, 16'hffff, 16'd0});
    xyz_pending_q.push_back({16'hffff, 16'd1, 16'd0});
    xyz_pending_q.push_back({16'd0, 16'd1, 16'd0});
    xyz_pending_q.push_back({16'd15568, 16'd16384, 16'd17827});
    xyz_pending_q.push_back({16'h5555, 16'haaaa, 16'h5555});
    xyz_pending_q.push_back({16'haaaa, 16'h5555, 16'haaaa});
    xyz_pending_q.push_back({16'd1, 16'd200, 16'd1});
    xyz_pending_q.push_back({16'hffff, 16'd146, 16'hffff});
    for (int ph = 0; ph < 8; ph++) begin
      if (sel_plan[ph] >= 0) reg_write(REG_ILLUM_SEL, DATA_W'(sel_plan[ph]));
      if (ph == 4) reg_write(REG_UNUSED, DATA_W'(ILLUM_E));
      for (int i = 0; i < 142; i++) xyz_pending_q.push_back(random_xyz());
      drain();
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### xyz_to_luv_pixel_top.f
hw/rtl/xyzluv_pkg.sv
hw/rtl/xyzluv_div.sv
hw/rtl/xyzluv_cbrt.sv
hw/rtl/xyzluv_light.sv
hw/rtl/xyz_to_luv_pixel_top.sv
verif/testbench.sv
